@@ rtl/lob_pkg.sv @@
// ----------------------------------------------------------------------------
// lob_pkg
// shared sizes, status codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package lob_pkg;

    localparam int PRICE_LEVELS = 256;
    localparam int LEVEL_DEPTH  = 16;
    localparam int ID_SPACE     = 1024;

    localparam int ID_W    = 10;
    localparam int PRICE_W = 8;
    localparam int POS_W   = 4;
    localparam int CNT_W   = 5;
    localparam int ST_W    = 3;

    // counts table is addressed by {side, price}
    localparam int CNT_AW  = 1 + PRICE_W;
    // slot table is addressed by {side, price, position}
    localparam int SLOT_AW = 1 + PRICE_W + POS_W;

    typedef enum logic [ST_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_CANCELLED = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_NOT_LIMIT = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef struct packed {
        logic               valid;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [POS_W-1:0]   pos;
    } t_id_entry;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic look;
        logic cnt;
        logic mv;
        logic upd;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic cancel_hit;
        logic shift_needed;
        logic more;
    } t_stat;

endpackage

@@ rtl/lob_ctrl.sv @@
// ----------------------------------------------------------------------------
// lob_ctrl
// sequencer: clearing sweep, lookup, gap-closing loop and result hand-off
// ----------------------------------------------------------------------------
module lob_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  lob_pkg::t_stat i_stat,
    output lob_pkg::t_cmd  o_cmd
);
    import lob_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_LOOK  = 7'b0000100,
        S_CNT   = 7'b0001000,
        S_MV    = 7'b0010000,
        S_UPD   = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = i_stat.cancel_hit ? S_CNT : S_EMIT;
            end
            S_CNT: begin
                o_cmd.cnt = 1'b1;
                n_state   = i_stat.shift_needed ? S_MV : S_EMIT;
            end
            S_MV: begin
                o_cmd.mv = 1'b1;
                n_state  = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_stat.more ? S_MV : S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over an untaken beat");
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_LOOK))
        else $error("accepted beat not followed by lookup");
    a_rose_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result beat raised outside hand-off");

endmodule

@@ rtl/lob_dp.sv @@
// ----------------------------------------------------------------------------
// lob_dp
// datapath: id index, level counts and slot memories with item registers
// ----------------------------------------------------------------------------
module lob_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lob_pkg::t_cmd               i_cmd,
    output lob_pkg::t_stat              o_stat,
    input  logic                        i_action,
    input  logic [lob_pkg::ID_W-1:0]    i_order_id,
    input  logic                        i_order_side,
    input  logic [lob_pkg::PRICE_W-1:0] i_price_tick,
    input  logic                        i_is_limit,
    output logic [lob_pkg::ST_W-1:0]    o_status,
    output logic [lob_pkg::POS_W-1:0]   o_queue_position,
    output logic [lob_pkg::CNT_W-1:0]   o_level_count
);
    import lob_pkg::*;

    t_id_entry        id_mem [ID_SPACE];
    logic [CNT_W-1:0] cn_mem [2*PRICE_LEVELS];
    logic [ID_W-1:0]  sl_mem [2*PRICE_LEVELS*LEVEL_DEPTH];

    t_id_entry           id_rd, id_wd;
    logic [ID_W-1:0]     id_ra, id_wa;
    logic                id_we;
    logic [CNT_W-1:0]    cn_rd, cn_wd;
    logic [CNT_AW-1:0]   cn_ra, cn_wa;
    logic                cn_we;
    logic [ID_W-1:0]     sl_rd, sl_wd;
    logic [SLOT_AW-1:0]  sl_ra, sl_wa;
    logic                sl_we;

    logic [ID_W-1:0]    r_clr;
    logic               r_action, r_side, r_limit;
    logic [ID_W-1:0]    r_id, r_moved;
    logic [PRICE_W-1:0] r_price, r_cprice;
    logic               r_cside;
    logic [POS_W-1:0]   r_cpos, r_p;
    logic [CNT_W-1:0]   r_cnt, cnt_c;
    t_status            r_st;
    logic [POS_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_lvl;
    logic               add_full, add_ok;

    // stored counts never exceed the depth; clamp anyway
    assign cnt_c    = (cn_rd > CNT_W'(LEVEL_DEPTH)) ? CNT_W'(LEVEL_DEPTH) : cn_rd;
    assign add_full = (cn_rd >= CNT_W'(LEVEL_DEPTH));
    assign add_ok   = !r_action && r_limit && !id_rd.valid && !add_full;

    assign o_stat.clr_last     = (r_clr == ID_W'(ID_SPACE - 1));
    assign o_stat.cancel_hit   = r_action && id_rd.valid;
    assign o_stat.shift_needed = ({1'b0, r_cpos} + CNT_W'(1)) < cnt_c;
    assign o_stat.more         = ({1'b0, r_p} + CNT_W'(2)) < r_cnt;

    always_comb begin
        id_we = 1'b0; id_wa = r_clr; id_wd = '0; id_ra = r_moved;
        cn_we = 1'b0; cn_wa = r_clr[CNT_AW-1:0]; cn_wd = '0;
        cn_ra = {r_side, r_price};
        sl_we = 1'b0; sl_wa = {r_side, r_price, cn_rd[POS_W-1:0]}; sl_wd = r_id;
        sl_ra = {r_cside, r_cprice, r_cpos + POS_W'(1)};
        if (i_cmd.clr_step) begin
            id_we = 1'b1;
            cn_we = 1'b1;
        end
        if (i_cmd.capture) begin
            id_ra = i_order_id;
            cn_ra = {i_order_side, i_price_tick};
        end
        if (i_cmd.look) begin
            if (add_ok) begin
                id_we = 1'b1; id_wa = r_id;
                id_wd = '{valid: 1'b1, side: r_side, price: r_price,
                          pos: cn_rd[POS_W-1:0]};
                cn_we = 1'b1; cn_wa = {r_side, r_price}; cn_wd = cn_rd + CNT_W'(1);
                sl_we = 1'b1;
            end
            if (o_stat.cancel_hit) begin
                id_we = 1'b1; id_wa = r_id;
                id_wd = id_rd; id_wd.valid = 1'b0;
                cn_ra = {id_rd.side, id_rd.price};
            end
        end
        if (i_cmd.cnt && ({1'b0, r_cpos} < cnt_c) && !o_stat.shift_needed) begin
            cn_we = 1'b1; cn_wa = {r_cside, r_cprice}; cn_wd = cnt_c - CNT_W'(1);
        end
        if (i_cmd.mv) begin
            sl_we = 1'b1; sl_wa = {r_cside, r_cprice, r_p}; sl_wd = sl_rd;
            id_ra = sl_rd;
        end
        if (i_cmd.upd) begin
            if (id_rd.valid) begin
                id_we = 1'b1; id_wa = r_moved;
                id_wd = id_rd; id_wd.pos = r_p;
            end
            sl_ra = {r_cside, r_cprice, r_p + POS_W'(2)};
            if (!o_stat.more) begin
                cn_we = 1'b1; cn_wa = {r_cside, r_cprice}; cn_wd = r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (id_we) id_mem[id_wa] <= id_wd;
        id_rd <= id_mem[id_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cn_we) cn_mem[cn_wa] <= cn_wd;
        cn_rd <= cn_mem[cn_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sl_we) sl_mem[sl_wa] <= sl_wd;
        sl_rd <= sl_mem[sl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_cmd.clr_step) r_clr <= r_clr + ID_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_id     <= i_order_id;
            r_side   <= i_order_side;
            r_price  <= i_price_tick;
            r_limit  <= i_is_limit;
        end
        if (i_cmd.look) begin
            r_cside  <= id_rd.side;
            r_cprice <= id_rd.price;
            r_cpos   <= id_rd.pos;
            if (!r_action) begin
                priority if (!r_limit) begin
                    r_st  <= ST_NOT_LIMIT;
                    r_pos <= '0;
                    r_lvl <= cn_rd;
                end else if (id_rd.valid) begin
                    r_st  <= ST_DUPLICATE;
                    r_pos <= '0;
                    r_lvl <= cn_rd;
                end else if (add_full) begin
                    r_st  <= ST_FULL;
                    r_pos <= '0;
                    r_lvl <= cn_rd;
                end else begin
                    r_st  <= ST_ADDED;
                    r_pos <= cn_rd[POS_W-1:0];
                    r_lvl <= cn_rd + CNT_W'(1);
                end
            end else begin
                r_st  <= ST_NOT_FOUND;
                r_pos <= '0;
                r_lvl <= '0;
            end
        end
        if (i_cmd.cnt) begin
            r_cnt <= cnt_c;
            r_p   <= r_cpos;
            r_st  <= ST_CANCELLED;
            r_pos <= r_cpos;
            r_lvl <= ({1'b0, r_cpos} < cnt_c) ? cnt_c - CNT_W'(1) : cnt_c;
        end
        if (i_cmd.mv) r_moved <= sl_rd;
        if (i_cmd.upd) r_p <= r_p + POS_W'(1);
        if (i_cmd.load_out) begin
            o_status         <= r_st;
            o_queue_position <= r_pos;
            o_level_count    <= r_lvl;
        end
    end

endmodule

@@ rtl/limit_order_book_add_cancel.sv @@
// ----------------------------------------------------------------------------
// limit_order_book_add_cancel
// bid/ask price levels kept as id fifos, with an id index; add and cancel
// ----------------------------------------------------------------------------
// add or rejected item: accept, then the lookup and hand-off states, then the result beat
// cancel: adds a count state, then a move and an update step per later order shifted
// one item at a time; the gap-closing loop over the slot memory sets the rate
// reset: a sweep over the id space clears the id index and level counts, stall held
module limit_order_book_add_cancel (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_action,
    input  logic [lob_pkg::ID_W-1:0]    i_order_id,
    input  logic                        i_order_side,
    input  logic [lob_pkg::PRICE_W-1:0] i_price_tick,
    input  logic                        i_is_limit,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [lob_pkg::ST_W-1:0]    o_status,
    output logic [lob_pkg::POS_W-1:0]   o_queue_position,
    output logic [lob_pkg::CNT_W-1:0]   o_level_count
);
    import lob_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    lob_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lob_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_action         (i_action),
        .i_order_id       (i_order_id),
        .i_order_side     (i_order_side),
        .i_price_tick     (i_price_tick),
        .i_is_limit       (i_is_limit),
        .o_status         (o_status),
        .o_queue_position (o_queue_position),
        .o_level_count    (o_level_count)
    );

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// add/cancel order book check: a scoreboard model of the bid and ask levels
// and the id index predicts every status beat, compared field by field
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lob_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_action;
    logic [ID_W-1:0]    i_order_id;
    logic               i_order_side;
    logic [PRICE_W-1:0] i_price_tick;
    logic               i_is_limit;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [ST_W-1:0]    o_status;
    logic [POS_W-1:0]   o_queue_position;
    logic [CNT_W-1:0]   o_level_count;

    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] count;
    } t_book_reply;

    limit_order_book_add_cancel DUT (.*);

    // book mirror
    logic [ID_W-1:0]  level_ids [2][PRICE_LEVELS][LEVEL_DEPTH];
    logic [CNT_W-1:0] level_fill [2][PRICE_LEVELS];
    t_id_entry        order_index [ID_SPACE];
    t_book_reply      pending_replies [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int idle_cycles;
    int replies_seen;
    int adds_done;
    int cancels_done;
    bit timed_out;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_book_reply book_apply(input logic act, input logic [ID_W-1:0] id,
                                               input logic sd, input logic [PRICE_W-1:0] px,
                                               input logic lim);
        t_book_reply r;
        t_id_entry   e;
        logic [CNT_W-1:0] n;
        r.pos = '0;
        if (act == 1'b0) begin
            n = level_fill[sd][px];
            r.count = n;
            if (!lim) begin
                r.status = ST_NOT_LIMIT;
            end else if (order_index[id].valid) begin
                r.status = ST_DUPLICATE;
            end else if (n >= LEVEL_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                level_ids[sd][px][n] = id;
                level_fill[sd][px] = n + CNT_W'(1);
                order_index[id] = '{valid: 1'b1, side: sd, price: px, pos: n[POS_W-1:0]};
                r.status = ST_ADDED;
                r.pos = n[POS_W-1:0];
                r.count = n + CNT_W'(1);
                adds_done++;
            end
        end else begin
            e = order_index[id];
            if (!e.valid) begin
                r.status = ST_NOT_FOUND;
                r.count = '0;
            end else begin
                n = level_fill[e.side][e.price];
                order_index[id].valid = 1'b0;
                for (int p = int'(e.pos); p + 1 < n; p++) begin
                    level_ids[e.side][e.price][p] = level_ids[e.side][e.price][p+1];
                    order_index[level_ids[e.side][e.price][p]].pos = p[POS_W-1:0];
                end
                level_fill[e.side][e.price] = n - CNT_W'(1);
                r.status = ST_CANCELLED;
                r.pos = e.pos;
                r.count = n - CNT_W'(1);
                cancels_done++;
            end
        end
        return r;
    endfunction

    task automatic send_order(input logic act, input logic [ID_W-1:0] id, input logic sd,
                              input logic [PRICE_W-1:0] px, input logic lim);
        t_book_reply reply;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_order_id   <= id;
        i_order_side <= sd;
        i_price_tick <= px;
        i_is_limit   <= lim;
        do @(posedge i_clk); while (o_in_stall);
        reply = book_apply(act, id, sd, px, lim);
        pending_replies = {pending_replies, reply};
        @(negedge i_clk);
    endtask

    task automatic drain_book;
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0 && !timed_out) @(negedge i_clk);
    endtask

    // random live id, or any id when the book is thin
    function automatic logic [ID_W-1:0] pick_live_id();
        logic [ID_W-1:0] id;
        for (int k = 0; k < 40; k++) begin
            id = ID_W'($urandom_range(ID_SPACE - 1));
            if (order_index[id].valid) return id;
        end
        return id;
    endfunction

    task automatic test_directed;
        // extremes of the fields, all reject paths and a mid-level cancel
        send_order(1'b1, 10'd0, 1'b0, 8'd0, 1'b1);
        send_order(1'b0, 10'd0, 1'b0, 8'd0, 1'b0);
        send_order(1'b0, 10'd1023, 1'b1, 8'd255, 1'b1);
        send_order(1'b0, 10'd1023, 1'b0, 8'd0, 1'b1);
        for (int k = 0; k < 16; k++)
            send_order(1'b0, 10'(k + 1), 1'b0, 8'd255, 1'b1);
        send_order(1'b0, 10'd700, 1'b0, 8'd255, 1'b1);
        send_order(1'b1, 10'd5, 1'b1, 8'd0, 1'b0);
        send_order(1'b1, 10'd1, 1'b0, 8'd0, 1'b0);
        send_order(1'b1, 10'd16, 1'b0, 8'd0, 1'b0);
        send_order(1'b1, 10'd1023, 1'b0, 8'd0, 1'b0);
        drain_book();
    endtask

    task automatic test_random_book(input int items);
        logic [PRICE_W-1:0] px;
        for (int k = 0; k < items; k++) begin
            // a few busy prices keep levels filling up and shifting
            px = ($urandom_range(3) != 0) ? 8'($urandom_range(5) * 51) : 8'($urandom);
            case ($urandom_range(9))
                0: send_order(1'b0, 10'($urandom), 1'($urandom), px, 1'b0);
                1: send_order(1'b1, 10'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
                2, 3, 4: send_order(1'b1, pick_live_id(), 1'($urandom), 8'($urandom),
                                    1'($urandom));
                default: send_order(1'b0, 10'($urandom), 1'($urandom), px, 1'b1);
            endcase
        end
        drain_book();
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_book_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: status %0d", o_status);
            end else begin
                want = pending_replies.pop_front();
                if (o_status !== want.status || o_queue_position !== want.pos ||
                    o_level_count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: expected st %0d pos %0d cnt %0d, got %0d %0d %0d",
                                 replies_seen, want.status, want.pos, want.count,
                                 o_status, o_queue_position, o_level_count);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = 1'b0;
        i_order_id = '0;
        i_order_side = 1'b0;
        i_price_tick = '0;
        i_is_limit = 1'b0;
        i_out_stall = 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 48;
        mismatches = 0;
        idle_cycles = 0;
        replies_seen = 0;
        adds_done = 0;
        cancels_done = 0;
        timed_out = 1'b0;
        for (int s = 0; s < 2; s++)
            for (int p = 0; p < PRICE_LEVELS; p++) level_fill[s][p] = '0;
        for (int i = 0; i < ID_SPACE; i++) order_index[i] = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_book(600);
        send_idle_pct = 48;
        recv_idle_pct = 38;
        test_random_book(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_book(600);

        repeat (40) @(negedge i_clk);
        $display("%0d beats checked, %0d orders added and %0d cancelled across both sides",
                 replies_seen, adds_done, cancels_done);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/lob_pkg.sv
rtl/lob_ctrl.sv
rtl/lob_dp.sv
rtl/limit_order_book_add_cancel.sv
test/testbench.sv
